// ----- hw/rtl/ssif_pkg.sv -----
// shared constants and control/status types for the sorted set intersection filter
package ssif_pkg;

	localparam int TABLE_DEPTH = 4096;
	localparam int ADDR_W      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
	localparam int HASH_W      = 64;
	localparam int OP_W        = 2;
	localparam int OVF_W       = 32;

	localparam logic [OP_W-1:0] OP_CLEAR = 2'd0;
	localparam logic [OP_W-1:0] OP_LOAD  = 2'd1;
	localparam logic [OP_W-1:0] OP_QUERY = 2'd2;

	typedef struct packed {
		logic clear;
		logic load;
		logic begin_search;
		logic step;
		logic check;
	} ssif_cmd_t;

	typedef struct packed {
		logic cnt_zero;
		logic more;
		logic in_range;
	} ssif_status_t;

endpackage

// ----- hw/rtl/sorted_set_intersection_filter.sv -----
// top level of the sorted set intersection filter
//
// A word is taken at a rising edge with start high and busy low. op selects
// clear (empty the table), load (append hash_value; hashes go in ascending
// order) or query (look hash_value up). Loads into a full table are dropped
// and counted internally as overflow, saturating.
// Clear, load and an unused op do not raise busy; busy stays low after them.
// A query runs a binary search over the loaded entries with one table probe
// per cycle: the registered read of the table memory feeds the compare that
// picks the next probe address. With n entries loaded that is at most
// floor(log2(n))+1 probes (13 for a full table of 4096), then a read and
// compare of the final candidate, which is skipped when the search runs past
// the last entry. busy stays high through the search and that compare; a
// query on an empty table does not search and leaves busy low.
// A hit puts the queried hash on match_value with match_valid high for one
// cycle, both registered from the final compare; a miss shows nothing. The
// receiver cannot stall, so results are never held.
// Reset empties the table and clears the overflow count and the strobe;
// table contents stay unset and only loaded entries ever decide a result.
module sorted_set_intersection_filter (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  logic [ssif_pkg::OP_W-1:0]    op,
	input  logic [ssif_pkg::HASH_W-1:0]  hash_value,
	output logic [ssif_pkg::HASH_W-1:0]  match_value,
	output logic                         match_valid
);
	import ssif_pkg::*;

	ssif_cmd_t    cmd;
	ssif_status_t status;

	ssif_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.op     (op),
		.status (status),
		.cmd    (cmd),
		.busy   (busy)
	);

	ssif_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.hash_value  (hash_value),
		.cmd         (cmd),
		.status      (status),
		.match_value (match_value),
		.match_valid (match_valid)
	);

endmodule

// ----- hw/rtl/ssif_ctrl.sv -----
// controller: sequences clear, load and the binary search of a query
module ssif_ctrl (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [ssif_pkg::OP_W-1:0]  op,
	input  ssif_pkg::ssif_status_t     status,
	output ssif_pkg::ssif_cmd_t        cmd,
	output logic                       busy
);
	import ssif_pkg::*;

	localparam logic [1:0] ST_IDLE   = 2'd0;
	localparam logic [1:0] ST_SEARCH = 2'd1;
	localparam logic [1:0] ST_CHECK  = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_n;
	logic       accept;

	assign busy   = (state_q != ST_IDLE);
	assign accept = start && !busy;

	always_comb begin
		state_n = state_q;
		cmd     = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					priority if (op == OP_CLEAR) begin
						cmd.clear = 1'b1;
					end else if (op == OP_LOAD) begin
						cmd.load = 1'b1;
					end else if (op == OP_QUERY) begin
						// an empty table never matches
						if (!status.cnt_zero) begin
							cmd.begin_search = 1'b1;
							state_n          = ST_SEARCH;
						end
					end
				end
			end
			ST_SEARCH: begin
				cmd.step = 1'b1;
				if (!status.more) begin
					state_n = status.in_range ? ST_CHECK : ST_IDLE;
				end
			end
			ST_CHECK: begin
				cmd.check = 1'b1;
				state_n   = ST_IDLE;
			end
			default: begin
				state_n = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_n;
		end
	end

endmodule

// ----- hw/rtl/ssif_dp.sv -----
// datapath: hash table memory, counters, search bounds and result register
module ssif_dp (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic [ssif_pkg::HASH_W-1:0]  hash_value,
	input  ssif_pkg::ssif_cmd_t          cmd,
	output ssif_pkg::ssif_status_t       status,
	output logic [ssif_pkg::HASH_W-1:0]  match_value,
	output logic                         match_valid
);
	import ssif_pkg::*;

	logic [HASH_W-1:0] mem [TABLE_DEPTH];
	logic [HASH_W-1:0] rd_q;
	logic [ADDR_W-1:0] rd_addr;

	logic [CNT_W-1:0]  cnt_q;
	logic [OVF_W-1:0]  ovf_q;
	logic [CNT_W-1:0]  lo_q;
	logic [CNT_W-1:0]  span_q;
	logic [HASH_W-1:0] key_q;
	logic [HASH_W-1:0] match_q;
	logic              match_valid_q;

	logic [CNT_W-1:0]  half;
	logic [CNT_W-1:0]  probe;
	logic [CNT_W-1:0]  lo_n;
	logic [CNT_W-1:0]  span_n;
	logic [CNT_W-1:0]  next_probe;
	logic [CNT_W-1:0]  cnt_half;
	logic              lt;
	logic              full;
	logic              hit;

	assign full     = (cnt_q == CNT_W'(TABLE_DEPTH));
	assign cnt_half = cnt_q >> 1;
	assign half     = span_q >> 1;
	assign probe    = lo_q + half;
	assign lt       = (rd_q < key_q);
	assign hit      = (rd_q == key_q);

	// rd_q holds the entry at probe; narrow the window around it
	always_comb begin
		if (lt) begin
			lo_n   = probe + CNT_W'(1);
			span_n = span_q - half - CNT_W'(1);
		end else begin
			lo_n   = lo_q;
			span_n = half;
		end
	end

	assign next_probe = (span_n != '0) ? (lo_n + (span_n >> 1)) : lo_n;

	always_comb begin
		if (cmd.begin_search) begin
			rd_addr = cnt_half[ADDR_W-1:0];
		end else begin
			rd_addr = next_probe[ADDR_W-1:0];
		end
	end

	assign status.cnt_zero = (cnt_q == '0);
	assign status.more     = (span_n != '0);
	assign status.in_range = (lo_n < cnt_q);

	always_ff @(posedge clk) begin
		if (cmd.load && !full) begin
			mem[cnt_q[ADDR_W-1:0]] <= hash_value;
		end
		rd_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q         <= '0;
			ovf_q         <= '0;
			match_valid_q <= 1'b0;
		end else begin
			match_valid_q <= cmd.check && hit;
			if (cmd.clear) begin
				cnt_q <= '0;
			end else if (cmd.load) begin
				if (!full) begin
					cnt_q <= cnt_q + CNT_W'(1);
				end else if (ovf_q != '1) begin
					// dropped load, saturating count
					ovf_q <= ovf_q + OVF_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.begin_search) begin
			key_q  <= hash_value;
			lo_q   <= '0;
			span_q <= cnt_q;
		end else if (cmd.step) begin
			lo_q   <= lo_n;
			span_q <= span_n;
		end
		if (cmd.check) begin
			match_q <= key_q;
		end
	end

	assign match_value = match_q;
	assign match_valid = match_valid_q;

endmodule

// ----- hw/rtl/ssif_checker.sv -----
// port-level checks for the sorted set intersection filter, bound to the top
module ssif_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         start,
	input logic                         busy,
	input logic [ssif_pkg::OP_W-1:0]    op,
	input logic                         match_valid
);
	import ssif_pkg::*;

	logic accept;
	assign accept = start && !busy;

	// a result only follows the final compare of a search
	a_strobe_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		match_valid |-> $past(busy))
		else $error("match strobe without a preceding search");

	a_strobe_idle: assert property (@(posedge clk) disable iff (!arst_n)
		match_valid |-> !busy)
		else $error("match strobe while busy");

	a_single_strobe: assert property (@(posedge clk) disable iff (!arst_n)
		match_valid |=> !match_valid)
		else $error("match strobe longer than one cycle");

	// clear, load and unused codes finish in the cycle they are taken
	a_short_ops: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && op != OP_QUERY) |=> !busy)
		else $error("non-query word left the block busy");

	a_no_strobe_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !match_valid)
		else $error("match strobe right after a word was taken");

endmodule

bind sorted_set_intersection_filter ssif_checker u_ssif_checker (.*);
